// File: sv/kcnc_pkg.sv
// ----------------------------------------------------------------------------
// kcnc_pkg
// Shared widths, register indexes and constants for the kernel convolution
// filter with normalize and clamp.
// ----------------------------------------------------------------------------
package kcnc_pkg;

  localparam int PIX_W   = 8;
  localparam int ROW_W   = 12;
  localparam int COL_W   = 11;
  localparam int REG_W   = 12;
  localparam int COEF_W  = 60;
  localparam int FIELD_W = 12;
  localparam int KMAX    = 5;
  localparam int IDX_W   = 3;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_DIVISOR      = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_ROW_A   = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_ROW_B   = 3'd4;
  localparam logic [IDX_W-1:0] REG_COEF_ROW_C   = 3'd5;
  localparam logic [IDX_W-1:0] REG_COEF_ROW_D   = 3'd6;
  localparam logic [IDX_W-1:0] REG_COEF_ROW_E   = 3'd7;

  localparam logic [REG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [REG_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [REG_W-1:0] DIV_RST    = 12'd1;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] value;
  } norm_res_t;

endpackage

// File: sv/kernel_convolution_normalize_clamp.sv
// ----------------------------------------------------------------------------
// kernel_convolution_normalize_clamp
// KxK image convolution over a raster pixel stream with divide and clamp.
// ----------------------------------------------------------------------------
// Pixels enter on in_valid/in_ready in raster order. Each accepted item
// updates the line memory and the window; when the window lies fully inside
// the image one filtered pixel leaves on out_valid/out_ready, tagged with the
// row and column of the window center. Border pixels produce no item.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// One item at a time: a border item passes through the line memory read,
// then the write back and window shift. An interior item then runs the
// single multiply-accumulate pass over the window and the normalizer, which
// clamps an out-of-range sum at once and otherwise runs the bit-serial
// divider. The output register holds a finished result; if the
// receiver stalls, the block holds the next result until the register frees
// and takes no new item meanwhile. Reset clears counters, control and the
// registers to their defaults; the line memory is not cleared.
// ----------------------------------------------------------------------------
module kernel_convolution_normalize_clamp import kcnc_pkg::*; #(
  parameter int KERNEL_SIZE = 3,
  parameter int MAX_WIDTH   = 2048,
  parameter int COEF_BITS   = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  in_pixel_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  out_pixel_out,
  output logic [ROW_W-1:0]  out_row,
  output logic [COL_W-1:0]  out_col,
  output logic              out_frame_done,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0] cfg_wdata
);

  localparam int LINES = KERNEL_SIZE - 1;
  localparam int LW    = LINES * PIX_W;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int RC_W  = $clog2(KERNEL_SIZE);
  localparam int PROD_W = PIX_W + 1 + COEF_BITS;
  localparam int SUM_W = PROD_W + $clog2(KERNEL_SIZE * KERNEL_SIZE);
  localparam int OFF   = KERNEL_SIZE / 2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_MAC   = 6'b000100,
    S_START = 6'b001000,
    S_WAIT  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r;

  logic [REG_W-1:0]  width_r, height_r, div_r;
  logic [COEF_W-1:0] coef_r [KMAX];

  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;

  logic [PIX_W-1:0] px_r;
  logic [AW-1:0]    addr_r;
  logic             emit_r;
  logic [ROW_W-1:0] orow_r;
  logic [COL_W-1:0] ocol_r;
  logic             fdone_r;

  logic [LW-1:0]    lmem [MAX_WIDTH];
  logic [LW-1:0]    rd_r;
  logic [LW-1:0]    wr_word;

  logic [PIX_W-1:0] win_r [KERNEL_SIZE][KERNEL_SIZE];

  logic [RC_W-1:0]         mr_r, mc_r;
  logic signed [SUM_W-1:0] acc_r;
  logic signed [PROD_W-1:0] prod;
  logic [FIELD_W-1:0]      cfield;

  logic [PIX_W-1:0] res_r;
  norm_res_t        nres;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_fd_r;

  logic [REG_W-1:0] w_eff, h_eff;
  logic [REG_W:0]   col_p1, row_p1;
  logic             accept, emit_nxt, col_wrap, row_wrap, slot_free;
  logic [AW-1:0]    idx;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      div_r    <= DIV_RST;
      for (int i = 0; i < KMAX; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r   <= cfg_wdata[REG_W-1:0];
        REG_IMAGE_HEIGHT: height_r  <= cfg_wdata[REG_W-1:0];
        REG_DIVISOR:      div_r     <= cfg_wdata[REG_W-1:0];
        REG_COEF_ROW_A:   coef_r[0] <= cfg_wdata;
        REG_COEF_ROW_B:   coef_r[1] <= cfg_wdata;
        REG_COEF_ROW_C:   coef_r[2] <= cfg_wdata;
        REG_COEF_ROW_D:   coef_r[3] <= cfg_wdata;
        REG_COEF_ROW_E:   coef_r[4] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- position and border decision ----
  assign w_eff = (width_r == '0) ? REG_W'(1) :
                 (width_r > REG_W'(MAX_WIDTH)) ? REG_W'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r == '0) ? REG_W'(1) : height_r;

  assign col_p1   = (REG_W+1)'(col_r) + (REG_W+1)'(1);
  assign row_p1   = (REG_W+1)'(row_r) + (REG_W+1)'(1);
  assign col_wrap = col_p1 >= (REG_W+1)'(w_eff);
  assign row_wrap = row_p1 >= (REG_W+1)'(h_eff);

  assign emit_nxt = (row_r >= ROW_W'(KERNEL_SIZE-1)) && (col_r >= COL_W'(KERNEL_SIZE-1))
                  && (row_r < h_eff) && (REG_W'(col_r) < w_eff);

  assign idx = (32'(col_r) < MAX_WIDTH) ? col_r[AW-1:0] : AW'(MAX_WIDTH-1);

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_r <= '0;
        row_r <= row_wrap ? '0 : row_p1[ROW_W-1:0];
      end else begin
        col_r <= col_p1[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r    <= in_pixel_in;
      addr_r  <= idx;
      emit_r  <= emit_nxt;
      orow_r  <= row_r - ROW_W'(OFF);
      ocol_r  <= col_r - COL_W'(OFF);
      fdone_r <= row_wrap && col_wrap;
    end
  end

  // ---- line memory: read on accept, write back in the cycle after ----
  always_comb begin
    wr_word = rd_r;
    for (int r = 0; r < LINES - 1; r++)
      wr_word[r*PIX_W +: PIX_W] = rd_r[(r+1)*PIX_W +: PIX_W];
    wr_word[(LINES-1)*PIX_W +: PIX_W] = px_r;
  end

  always_ff @(posedge clk) begin
    if (accept) rd_r <= lmem[idx];
    if (state_r == S_SHIFT) lmem[addr_r] <= wr_word;
  end

  // ---- window shift, oldest row at the top ----
  always_ff @(posedge clk) begin
    if (state_r == S_SHIFT) begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        for (int c = 0; c < KERNEL_SIZE - 1; c++)
          win_r[r][c] <= win_r[r][c+1];
        if (r < LINES) win_r[r][KERNEL_SIZE-1] <= rd_r[r*PIX_W +: PIX_W];
        else           win_r[r][KERNEL_SIZE-1] <= px_r;
      end
    end
  end

  // ---- multiply-accumulate, one tap per cycle ----
  assign cfield = coef_r[mr_r][FIELD_W*mc_r +: FIELD_W];
  assign prod   = $signed({1'b0, win_r[mr_r][mc_r]}) *
                  $signed(cfield[COEF_BITS-1:0]);

  kcnc_norm #(.SUM_W(SUM_W)) u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == S_START),
    .sum     (acc_r),
    .divisor (div_r),
    .res     (nres)
  );

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mr_r        <= '0;
      mc_r        <= '0;
    end else begin
      // in the done state the output register is reloaded below instead
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) state_r <= S_SHIFT;
        end
        S_SHIFT: begin
          acc_r   <= '0;
          mr_r    <= '0;
          mc_r    <= '0;
          state_r <= emit_r ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          acc_r <= acc_r + SUM_W'(prod);
          if (mc_r == RC_W'(KERNEL_SIZE-1)) begin
            mc_r <= '0;
            if (mr_r == RC_W'(KERNEL_SIZE-1)) state_r <= S_START;
            else                              mr_r    <= mr_r + RC_W'(1);
          end else begin
            mc_r <= mc_r + RC_W'(1);
          end
        end
        S_START: state_r <= S_WAIT;
        S_WAIT: begin
          if (nres.done) begin
            res_r   <= nres.value;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_pix_r   <= res_r;
            out_row_r   <= orow_r;
            out_col_r   <= ocol_r;
            out_fd_r    <= fdone_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pix_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_frame_done = out_fd_r;

`ifndef SYNTHESIS
  a_accept_shift: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_SHIFT)
    else $error("accepted item did not reach window update");
  a_mac_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAC |-> (mr_r <= RC_W'(KERNEL_SIZE-1)) && (mc_r <= RC_W'(KERNEL_SIZE-1)))
    else $error("tap index beyond kernel");
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && slot_free |=> out_valid_r)
    else $error("finished result not presented");
`endif

endmodule

// File: sv/kcnc_norm.sv
// ----------------------------------------------------------------------------
// kcnc_norm
// Divides a signed weighted sum by the divisor, truncating toward zero, and
// clamps to 0..255. Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kcnc_norm import kcnc_pkg::*; #(
  parameter int SUM_W = 26
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum,
  input  logic [REG_W-1:0]        divisor,
  output norm_res_t               res
);

  typedef enum logic [2:0] {
    N_IDLE = 3'b001,
    N_CHK  = 3'b010,
    N_DIV  = 3'b100
  } nstate_t;

  nstate_t                 st_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0]        rem_r;
  logic [REG_W-1:0]        d_r;
  logic [2:0]              bit_r;
  logic [PIX_W-1:0]        q_r;
  logic                    done_r;
  logic [SUM_W-1:0]        dsh;
  logic [SUM_W-1:0]        dtop;
  logic [SUM_W:0]          dlim;

  assign dsh  = SUM_W'(d_r) << bit_r;
  assign dtop = SUM_W'(d_r) << PIX_W;
  assign dlim = (SUM_W+1)'(d_r) << ({1'b0, bit_r} + 4'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= N_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        N_IDLE: begin
          if (start) begin
            sum_r <= sum;
            d_r   <= (divisor == '0) ? REG_W'(1) : divisor;
            st_r  <= N_CHK;
          end
        end
        N_CHK: begin
          if (sum_r < 0) begin
            q_r    <= PIX_MIN;
            done_r <= 1'b1;
            st_r   <= N_IDLE;
          end else if (SUM_W'(sum_r) >= dtop) begin
            q_r    <= PIX_MAX;
            done_r <= 1'b1;
            st_r   <= N_IDLE;
          end else begin
            rem_r <= SUM_W'(sum_r);
            bit_r <= 3'd7;
            q_r   <= '0;
            st_r  <= N_DIV;
          end
        end
        N_DIV: begin
          if (rem_r >= dsh) begin
            rem_r        <= rem_r - dsh;
            q_r[bit_r]   <= 1'b1;
          end
          if (bit_r == 3'd0) begin
            done_r <= 1'b1;
            st_r   <= N_IDLE;
          end else begin
            bit_r <= bit_r - 3'd1;
          end
        end
        default: st_r <= N_IDLE;
      endcase
    end
  end

  assign res.done  = done_r;
  assign res.value = q_r;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == N_DIV |-> {1'b0, rem_r} < dlim)
    else $error("remainder out of range during divide");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held longer than one cycle");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> st_r == N_IDLE)
    else $error("start while divider busy");
`endif

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 convolution filter with divide and clamp.
// A behavioral window filter in the scoreboard predicts every interior pixel
// of whole frames. Sizes, divisor and kernel rows change between frames.
// Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kcnc_pkg::*;

  localparam int K      = 3;
  localparam int MAXW   = 2048;
  localparam int CBITS  = 12;
  localparam int LIMIT  = 5000;
  localparam int SETTLE = 40;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } filt_px_t;

  class filter_scoreboard;
    logic [REG_W-1:0]  img_w, img_h, div_reg;
    logic [COEF_W-1:0] krow[5];
    logic [PIX_W-1:0]  line_mem[K-1][MAXW];
    logic [PIX_W-1:0]  win[K][K];
    logic [ROW_W-1:0]  row_cnt;
    logic [COL_W-1:0]  col_cnt;
    filt_px_t          expected_px[$];
    int                mismatches;
    int                results_seen;
    int                clamp_hi, clamp_lo;

    function new();
      img_w = WIDTH_RST;
      img_h = HEIGHT_RST;
      div_reg = DIV_RST;
      foreach (krow[i]) krow[i] = '0;
      foreach (line_mem[r, c]) line_mem[r][c] = '0;
      foreach (win[r, c]) win[r][c] = '0;
      row_cnt = '0;
      col_cnt = '0;
      mismatches = 0;
      results_seen = 0;
      clamp_hi = 0;
      clamp_lo = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH:  img_w = data[REG_W-1:0];
        REG_IMAGE_HEIGHT: img_h = data[REG_W-1:0];
        REG_DIVISOR:      div_reg = data[REG_W-1:0];
        default:          krow[idx - REG_COEF_ROW_A] = data;
      endcase
    endfunction

    function int eff_w();
      if (img_w == 0) return 1;
      if (img_w > MAXW) return MAXW;
      return img_w;
    endfunction

    function int eff_h();
      return (img_h == 0) ? 1 : img_h;
    endfunction

    function longint coef(int r, int c);
      logic [CBITS-1:0] f;
      f = krow[r][12*c +: CBITS];
      return longint'($signed(f));
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px);
      int      w, h, d, rr, cc, idx;
      logic [PIX_W-1:0] colv[K];
      longint  acc, q;
      filt_px_t e;
      w = eff_w();
      h = eff_h();
      d = (div_reg == 0) ? 1 : div_reg;
      rr = row_cnt;
      cc = col_cnt;
      idx = (cc < MAXW) ? cc : MAXW - 1;
      for (int r = 0; r < K - 1; r++) colv[r] = line_mem[r][idx];
      colv[K-1] = px;
      for (int r = 0; r + 1 < K - 1; r++) line_mem[r][idx] = line_mem[r+1][idx];
      line_mem[K-2][idx] = px;
      for (int r = 0; r < K; r++) begin
        for (int c = 0; c + 1 < K; c++) win[r][c] = win[r][c+1];
        win[r][K-1] = colv[r];
      end
      if (rr >= K - 1 && cc >= K - 1 && rr < h && cc < w) begin
        acc = 0;
        for (int r = 0; r < K; r++)
          for (int c = 0; c < K; c++)
            acc += longint'(win[r][c]) * coef(r, c);
        q = acc / d;  // truncates toward zero
        if (q < 0) begin
          q = 0;
          clamp_lo++;
        end
        if (q > 255) begin
          q = 255;
          clamp_hi++;
        end
        e.pix  = q[PIX_W-1:0];
        e.row  = ROW_W'(rr - K/2);
        e.col  = COL_W'(cc - K/2);
        e.done = (rr + 1 >= h && cc + 1 >= w);
        expected_px.insert(expected_px.size(), e);
      end
      if (cc + 1 >= w) begin
        col_cnt = '0;
        row_cnt = (rr + 1 >= h) ? '0 : ROW_W'(rr + 1);
      end else begin
        col_cnt = COL_W'(cc + 1);
      end
    endfunction

    function void check_pixel(filt_px_t got);
      filt_px_t e;
      results_seen++;
      if (expected_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result pix=%0d row=%0d col=%0d done=%0b",
                   got.pix, got.row, got.col, got.done);
        return;
      end
      e = expected_px.pop_front();
      if (got.pix !== e.pix || got.row !== e.row || got.col !== e.col ||
          got.done !== e.done) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp pix=%0d row=%0d col=%0d done=%0b",
                   e.pix, e.row, e.col, e.done);
          $display("  got pix=%0d row=%0d col=%0d done=%0b",
                   got.pix, got.row, got.col, got.done);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  in_pixel_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PIX_W-1:0]  out_pixel_out;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic              out_frame_done;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [COEF_W-1:0] cfg_wdata = '0;

  filter_scoreboard sb = new();
  int  idle_cycles = 0;
  int  pixels_sent = 0;
  int  frames_sent = 0;
  bit  stall_on = 1'b0;
  bit  gaps_on = 1'b0;
  bit  took_in, took_out;

  always #10 clk = ~clk;

  kernel_convolution_normalize_clamp dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixel_out(out_pixel_out),
    .out_row(out_row), .out_col(out_col), .out_frame_done(out_frame_done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sample handshakes mid-cycle; inputs only move at rising edges
  always @(negedge clk) begin
    filt_px_t got;
    took_in  = in_valid && in_ready;
    took_out = out_valid && out_ready;
    if (took_in) sb.note_pixel(in_pixel_in);
    if (took_out) begin
      got.pix  = out_pixel_out;
      got.row  = out_row;
      got.col  = out_col;
      got.done = out_frame_done;
      sb.check_pixel(got);
    end
    if (rst_n && !took_in && !took_out) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (stall_on && rst_n) begin
      stall_left <= gap_len();
      out_ready <= ($urandom_range(0, 1) != 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] p);
    int g;
    g = gaps_on ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= p;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pixels_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] pack_row(int c0, int c1, int c2, int c3, int c4);
    logic [11:0] f[5];
    f[0] = 12'(c0); f[1] = 12'(c1); f[2] = 12'(c2); f[3] = 12'(c3); f[4] = 12'(c4);
    return {f[4], f[3], f[2], f[1], f[0]};
  endfunction

  function automatic logic [COEF_W-1:0] rand60();
    return COEF_W'({$urandom, $urandom});
  endfunction

  function automatic int small_coef();
    return $urandom_range(0, 16) - 8;
  endfunction

  // mode 0 random, 1 all 255, 2 all 0, 3 mostly extremes
  task automatic send_run(int total, int mode);
    logic [PIX_W-1:0] p;
    for (int i = 0; i < total; i++) begin
      case (mode)
        1: p = PIX_MAX;
        2: p = PIX_MIN;
        3: p = ($urandom_range(0, 1) != 0) ? PIX_MAX : PIX_W'($urandom_range(0, 3));
        default: p = PIX_W'($urandom);
      endcase
      send_pixel(p);
    end
  endtask

  task automatic send_frames(int n, int mode);
    drain();
    send_run(sb.eff_w() * sb.eff_h() * n, mode);
    frames_sent += n;
    drain();
  endtask

  task automatic set_kernel_all(int v);
    for (int r = 0; r < 5; r++)
      write_reg(IDX_W'(REG_COEF_ROW_A + r), pack_row(v, v, v, v, v));
  endtask

  initial begin
    int w, h;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: positive clamp, negative clamp, identity with divisor zero, large divisor
    write_reg(REG_IMAGE_WIDTH, COEF_W'(3));
    write_reg(REG_IMAGE_HEIGHT, COEF_W'(3));
    write_reg(REG_DIVISOR, COEF_W'(1));
    set_kernel_all(12'h7FF);
    send_frames(1, 1);
    set_kernel_all(12'h800);
    send_frames(1, 1);
    set_kernel_all(0);
    write_reg(REG_COEF_ROW_B, pack_row(0, 1, 0, 0, 0));
    write_reg(REG_DIVISOR, COEF_W'(0));
    send_frames(1, 0);
    write_reg(REG_DIVISOR, COEF_W'(12'hFFF));
    set_kernel_all(12'h7FF);
    send_frames(1, 3);

    // size extremes and degenerate sizes
    gaps_on = 1'b1;
    stall_on = 1'b1;
    write_reg(REG_DIVISOR, COEF_W'(9));
    set_kernel_all(1);
    // oversized width, part of a row, then the size changes mid-frame
    write_reg(REG_IMAGE_WIDTH, COEF_W'(12'hFFF));
    write_reg(REG_IMAGE_HEIGHT, COEF_W'(3));
    drain();
    send_run(40, 0);
    drain();
    write_reg(REG_IMAGE_WIDTH, COEF_W'(0));
    write_reg(REG_IMAGE_HEIGHT, COEF_W'(24));
    send_frames(1, 2);
    write_reg(REG_IMAGE_WIDTH, COEF_W'(5));
    write_reg(REG_IMAGE_HEIGHT, COEF_W'(0));
    send_frames(2, 0);
    write_reg(REG_IMAGE_WIDTH, COEF_W'(2));
    write_reg(REG_IMAGE_HEIGHT, COEF_W'(4));
    send_frames(1, 0);

    // random frames, mostly small sizes and small kernels
    while (pixels_sent < 1050) begin
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      write_reg(REG_IMAGE_WIDTH, rand60() & ~60'hFFF | COEF_W'(w));
      write_reg(REG_IMAGE_HEIGHT, rand60() & ~60'hFFF | COEF_W'(h));
      write_reg(REG_DIVISOR, COEF_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                                 : $urandom_range(1, 40)));
      for (int r = 0; r < 5; r++)
        write_reg(IDX_W'(REG_COEF_ROW_A + r), ($urandom_range(0, 4) == 0) ? rand60() :
                  pack_row(small_coef(), small_coef(), small_coef(), $urandom, $urandom));
      send_frames($urandom_range(1, 2), ($urandom_range(0, 7) == 0) ? 3 : 0);
    end

    drain();
    $display("covered %0d pixels in %0d frames, %0d filtered results",
             pixels_sent, frames_sent, sb.results_seen);
    $display("clamped high %0d, clamped low %0d, mismatches %0d",
             sb.clamp_hi, sb.clamp_lo, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_px.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: kernel_convolution_normalize_clamp.f
sv/kcnc_pkg.sv
sv/kcnc_norm.sv
sv/kernel_convolution_normalize_clamp.sv
test/tb_top.sv
